/* rtl/mtd_pkg.sv */
// Package for the Morse timing decoder: constants, run state and result types.
// No dependencies; imported by the decoder top level and its testbench.
`default_nettype none

package mtd_pkg;

  localparam int TableDepth  = 63;
  localparam int TableAw     = 6;
  localparam int CharW       = 8;
  localparam int MaxElements = 5;
  localparam int CodeWidth   = 5;
  localparam int CountMax    = 7;
  localparam int ResDepth    = 4;

  localparam logic [7:0] CharOne   = 8'h31;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNl    = 8'h0A;
  localparam logic [7:0] CharSpace = 8'h20;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'd0,
    ST_MARK1 = 4'd1,
    ST_MARK2 = 4'd2,
    ST_MARK3 = 4'd3,
    ST_GAP1  = 4'd4,
    ST_GAP2  = 4'd5,
    ST_GAP3  = 4'd6,
    ST_GAP4  = 4'd7,
    ST_GAP5  = 4'd8,
    ST_GAP6  = 4'd9,
    ST_GAP7  = 4'd10
  } mtd_state_t;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } mtd_res_t;

endpackage

`default_nettype wire

/* rtl/mtd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; used for the symbol table of the Morse timing decoder.
`default_nettype none

module mtd_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/morse_timing_decoder.sv */
// Morse timing decoder top level: run-length timing, symbol build, table lookup.
// Depends on mtd_pkg and mtd_ram.
`default_nettype none

// Takes one item per cycle: a sample byte ('1' mark unit, '0' gap unit, newline)
// or a symbol table write, selected by in_tuser. Each item is decoded in the cycle
// it is accepted and gives zero, one or two characters, which queue in a
// four-deep result buffer; in_tready drops while more than two results wait, so
// a stream that yields one character per item runs at one item per cycle and the
// rate is otherwise set by how fast out_tready drains the buffer. The 63-entry
// symbol table sits in a RAM whose registered read port is addressed from the
// next symbol state, with a write bypass and per-entry valid bits so that every
// slot reads zero after reset until written; no clearing pass is needed.
module morse_timing_decoder #(
  parameter int MaxElems = mtd_pkg::MaxElements
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // sample_byte[7:0], entry_index[13:8],
                                       // entry_char[21:14], zero[23:22]
  input  wire logic [0:0]  in_tuser,   // func[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // out_char[7:0]
  output logic             out_tlast
);
  import mtd_pkg::*;

  localparam int ResAw = $clog2(ResDepth);
  localparam int ResCw = $clog2(ResDepth + 1);

  mtd_state_t            state_r, state_nxt;
  logic [CodeWidth-1:0]  code_r, code_nxt;
  logic [2:0]            cnt_r, cnt_nxt;
  logic [TableDepth-1:0] valid_r;

  logic                  lk_byp_r, lk_vld_r;
  logic [CharW-1:0]      lk_bdata_r;
  logic [CharW-1:0]      ram_q, lk_val, lk_char;
  logic [TableAw-1:0]    rd_addr;

  mtd_res_t              res_q_r [ResDepth];
  logic [ResAw-1:0]      wr_ptr_r, rd_ptr_r;
  logic [ResCw-1:0]      res_cnt_r;

  logic                  in_fire, out_fire, tbl_we, is_wr;
  logic [7:0]            sample;
  logic [TableAw-1:0]    wr_idx;
  logic [CharW-1:0]      wr_char;
  logic [1:0]            n_push;
  logic [CharW-1:0]      c0, c1;

  function automatic logic [TableAw-1:0] slot_of(input logic [2:0] n,
                                                  input logic [CodeWidth-1:0] code);
    logic [2:0]           ne;
    logic [CodeWidth-1:0] m;
    ne = (n > 3'(CodeWidth)) ? 3'(CodeWidth) : n;
    m  = CodeWidth'((7'd1 << ne) - 7'd1);
    return TableAw'(m) + TableAw'(code & m);
  endfunction

  assign sample   = in_tdata[7:0];
  assign wr_idx   = in_tdata[13:8];
  assign wr_char  = in_tdata[21:14];
  assign is_wr    = in_tuser[0];
  assign in_tready = (res_cnt_r <= ResCw'(ResDepth - 2));
  assign in_fire  = in_tvalid & in_tready;
  assign out_fire = out_tvalid & out_tready;
  assign tbl_we   = in_fire & is_wr & (wr_idx < TableAw'(TableDepth));

  // symbol table
  assign rd_addr = slot_of(cnt_nxt, code_nxt);

  mtd_ram #(
    .Width (CharW),
    .Depth (TableDepth)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (wr_idx),
    .wdata (wr_char),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      lk_byp_r <= 1'b0;
      lk_vld_r <= 1'b0;
    end else begin
      if (tbl_we) begin
        valid_r[wr_idx] <= 1'b1;
      end
      lk_byp_r <= tbl_we && (wr_idx == rd_addr);
      lk_vld_r <= valid_r[rd_addr];
    end
    lk_bdata_r <= wr_char;
  end

  assign lk_val  = lk_byp_r ? lk_bdata_r : (lk_vld_r ? ram_q : '0);
  assign lk_char = (cnt_r <= 3'(MaxElems) && cnt_r <= 3'(CodeWidth)) ? lk_val : '0;

  // timing state and symbol build
  always_comb begin
    logic add_el, dah, clr;
    add_el    = 1'b0;
    dah       = 1'b0;
    clr       = 1'b0;
    state_nxt = state_r;
    code_nxt  = code_r;
    cnt_nxt   = cnt_r;
    n_push    = 2'd0;
    c0        = lk_char;
    c1        = CharSpace;
    if (in_fire && !is_wr) begin
      if (sample == CharOne) begin
        state_nxt = ST_MARK1;
        case (state_r)
          ST_IDLE:  state_nxt = ST_MARK1;
          ST_MARK1: state_nxt = ST_MARK2;
          ST_MARK2: state_nxt = ST_MARK3;
          ST_MARK3: begin
            add_el = 1'b1;
            dah    = 1'b1;
          end
          ST_GAP1:  ;
          ST_GAP3: begin
            n_push = 2'd1;
            clr    = 1'b1;
          end
          ST_GAP7: begin
            n_push = 2'd2;
            clr    = 1'b1;
          end
          default:  clr = 1'b1;
        endcase
      end else if (sample == CharZero) begin
        state_nxt = ST_GAP1;
        case (state_r)
          ST_IDLE:  ;
          ST_MARK1: add_el = 1'b1;
          ST_MARK2: clr = 1'b1;
          ST_MARK3: begin
            add_el = 1'b1;
            dah    = 1'b1;
          end
          ST_GAP7: begin
            n_push = 2'd2;
            clr    = 1'b1;
          end
          ST_GAP1:  state_nxt = ST_GAP2;
          ST_GAP2:  state_nxt = ST_GAP3;
          ST_GAP3:  state_nxt = ST_GAP4;
          ST_GAP4:  state_nxt = ST_GAP5;
          ST_GAP5:  state_nxt = ST_GAP6;
          ST_GAP6:  state_nxt = ST_GAP7;
          default:  ;
        endcase
      end else if (sample == CharNl) begin
        n_push    = 2'd2;
        c1        = CharNl;
        clr       = 1'b1;
        state_nxt = ST_IDLE;
      end
    end
    if (add_el) begin
      for (int i = 0; i < CodeWidth; i++) begin
        if (cnt_r == 3'(i)) begin
          code_nxt[i] = dah;
        end
      end
      if (cnt_r < 3'(CountMax)) begin
        cnt_nxt = cnt_r + 3'd1;
      end
    end
    if (clr) begin
      code_nxt = '0;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      code_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // result buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      res_cnt_r <= '0;
    end else begin
      wr_ptr_r  <= wr_ptr_r + ResAw'(n_push);
      rd_ptr_r  <= rd_ptr_r + ResAw'(out_fire);
      res_cnt_r <= res_cnt_r + ResCw'(n_push) - ResCw'(out_fire);
    end
    if (n_push != 2'd0) begin
      res_q_r[wr_ptr_r] <= '{ch: c0, last: (n_push == 2'd1)};
    end
    if (n_push == 2'd2) begin
      res_q_r[wr_ptr_r + ResAw'(1)] <= '{ch: c1, last: 1'b1};
    end
  end

  assign out_tvalid = (res_cnt_r != '0);
  assign out_tdata  = res_q_r[rd_ptr_r].ch;
  assign out_tlast  = res_q_r[rd_ptr_r].last;

  // checks
  a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= ResCw'(ResDepth))
    else $error("result buffer overrun");

  a_nl_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !is_wr && sample == CharNl) |=> (state_r == ST_IDLE && cnt_r == '0))
    else $error("newline did not return to idle");

  a_code_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r < 3'(CodeWidth)) |-> ((code_r >> cnt_r) == '0))
    else $error("code bits set beyond element count");

  a_wr_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_wr) |=> (res_cnt_r <= $past(res_cnt_r)))
    else $error("table write produced a result");

endmodule

`default_nettype wire

/* test/tb_morse_timing_decoder.sv */
// Testbench for morse_timing_decoder: drives sample and table write items, predicts
// the decoded characters and checks every result item in order.
// Depends on mtd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_morse_timing_decoder;
  import mtd_pkg::*;

  localparam logic FuncSample = 1'b0;
  localparam logic FuncWrite  = 1'b1;

  class morse_checker;
    mtd_state_t  run_state;
    logic [4:0]  code_bits;
    logic [2:0]  n_elems;
    logic [7:0]  symbols [TableDepth];
    mtd_res_t    pending_chars[$];
    int unsigned n_errors;

    function new();
      run_state = ST_IDLE;
      code_bits = '0;
      n_elems   = '0;
      n_errors  = 0;
      foreach (symbols[i]) symbols[i] = 8'h00;
    endfunction

    function void clear_symbol();
      code_bits = '0;
      n_elems   = '0;
    endfunction

    function void add_element(logic dah);
      if (n_elems < CodeWidth) code_bits[n_elems] = dah;
      if (n_elems < CountMax) n_elems++;
    endfunction

    function logic [7:0] lookup_char();
      int mask;
      int slot;
      if (n_elems > MaxElements) return 8'h00;
      mask = (1 << n_elems) - 1;
      slot = mask + (int'(code_bits) & mask);
      if (slot >= TableDepth) return 8'h00;
      return symbols[slot];
    endfunction

    function void emit(logic [7:0] ch, logic last);
      pending_chars.push_back('{ch: ch, last: last});
    endfunction

    function void note_item(logic func, logic [23:0] data);
      logic [7:0] smp;
      logic [5:0] slot;
      int         gap;
      smp  = data[7:0];
      slot = data[13:8];
      if (func == FuncWrite) begin
        if (slot < TableDepth) symbols[slot] = data[21:14];
        return;
      end
      case (smp)
        CharOne: begin
          case (run_state)
            ST_IDLE:  run_state = ST_MARK1;
            ST_MARK1: run_state = ST_MARK2;
            ST_MARK2: run_state = ST_MARK3;
            ST_MARK3: begin
              add_element(1'b1);
              run_state = ST_MARK1;
            end
            default: begin
              gap = int'(run_state) - int'(ST_GAP1) + 1;
              if (gap == 3) begin
                emit(lookup_char(), 1'b1);
              end else if (gap == 7) begin
                emit(lookup_char(), 1'b0);
                emit(CharSpace, 1'b1);
              end
              if (gap != 1) clear_symbol();
              run_state = ST_MARK1;
            end
          endcase
        end
        CharZero: begin
          case (run_state)
            ST_IDLE:  run_state = ST_GAP1;
            ST_MARK1: begin
              add_element(1'b0);
              run_state = ST_GAP1;
            end
            ST_MARK2: begin
              clear_symbol();
              run_state = ST_GAP1;
            end
            ST_MARK3: begin
              add_element(1'b1);
              run_state = ST_GAP1;
            end
            ST_GAP7: begin
              emit(lookup_char(), 1'b0);
              emit(CharSpace, 1'b1);
              clear_symbol();
              run_state = ST_GAP1;
            end
            default: run_state = mtd_state_t'(run_state + 4'd1);
          endcase
        end
        CharNl: begin
          emit(lookup_char(), 1'b0);
          emit(CharNl, 1'b1);
          clear_symbol();
          run_state = ST_IDLE;
        end
        default: ;
      endcase
    endfunction

    function void flag(string msg);
      n_errors++;
      if (n_errors <= 10) $display("%s", msg);
    endfunction

    function void check_result(logic [7:0] ch, logic last);
      mtd_res_t want;
      if (pending_chars.size() == 0) begin
        flag($sformatf("unexpected item: char %02h last %0b", ch, last));
        return;
      end
      want = pending_chars.pop_front();
      if (ch !== want.ch || last !== want.last)
        flag($sformatf("mismatch: expected char %02h last %0b, got char %02h last %0b",
                       want.ch, want.last, ch, last));
    endfunction
  endclass

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;  // sample_byte[7:0], entry_index[13:8],
                                 // entry_char[21:14], zero[23:22]
  logic [0:0]  in_tuser   = '0;  // func[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;        // out_char[7:0]
  logic        out_tlast;

  morse_checker chk = new();
  int unsigned  sent_items = 0;

  morse_timing_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) chk.note_item(in_tuser[0], in_tdata);
      if (out_tvalid && out_tready) chk.check_result(out_tdata, out_tlast);
    end
  end

  // receiver: random stalls, one long hold-off to fill the block, one clean stretch
  initial begin
    int unsigned rx_cycle;
    rx_cycle = 0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle >= 500 && rx_cycle < 800) begin
        out_tready <= 1'b0;
      end else if (rx_cycle >= 900 && rx_cycle < 1100) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 7);
      end
    end
  end

  task automatic drive_item(input logic func, input logic [23:0] data);
    if (!(sent_items >= 500 && sent_items < 700) && $urandom_range(99) < 7) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= func;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_sample(input logic [7:0] b);
    drive_item(FuncSample, {2'b00, 8'($urandom_range(255)), 6'($urandom_range(63)), b});
  endtask

  task automatic send_samples(input string s);
    for (int i = 0; i < s.len(); i++) send_sample(s[i]);
  endtask

  task automatic send_write(input logic [5:0] slot, input logic [7:0] ch);
    drive_item(FuncWrite, {2'b00, ch, slot, 8'($urandom_range(255))});
  endtask

  initial begin
    int n_len;
    int pick;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty symbol on an unwritten table, then slot extremes
    send_sample(CharNl);
    send_write(6'd0, 8'hFF);
    send_write(6'd63, 8'h5A);
    send_write(6'd2, 8'h00);
    send_write(6'd1, 8'h45);
    // idle gap, short gap cleared by a mark, dit then a letter gap,
    // overlong mark, two-unit mark clearing the symbol
    send_samples("0010001111");
    send_samples("10");
    // word gap, then a further gap unit
    send_samples("100000000");
    send_sample(8'hFF);
    send_sample(8'h00);
    // newline with a mark still open
    send_samples("1\n");

    for (int i = 0; i < TableDepth; i++) send_write(6'(i), 8'($urandom_range(255)));

    while (sent_items < 850) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_write(6'($urandom_range(63)), 8'($urandom_range(255)));
      end else if (pick < 10) begin
        send_sample(8'($urandom_range(255)));
      end else if (pick < 16) begin
        send_sample($urandom_range(1) ? CharOne : CharZero);
      end else if (pick < 19) begin
        send_sample(CharNl);
      end else begin
        pick = $urandom_range(19);
        if (pick == 0) n_len = 0;
        else if (pick == 1) n_len = $urandom_range(6, 8);
        else n_len = $urandom_range(1, MaxElements);
        for (int e = 0; e < n_len; e++) begin
          if ($urandom_range(1)) send_samples("111");
          else send_sample(CharOne);
          if (e < n_len - 1) send_sample(CharZero);
        end
        pick = $urandom_range(9);
        if (pick < 6) send_samples("000");
        else if (pick < 9) send_samples("0000000");
        else send_sample(CharNl);
      end
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (chk.pending_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (chk.n_errors == 0 && chk.pending_chars.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
